[rtl/scra_pkg.sv]
// ----------------------------------------------------------------------------
// scra_pkg: shared types and constants
// Opcodes, sequencer states and the control bundle of the checksum accumulator.
// ----------------------------------------------------------------------------
package scra_pkg;

	localparam int WORD_W = 32;
	localparam int OP_W   = 2;
	localparam int TYPE_W = 8;

	localparam logic [OP_W-1:0] OP_SEND  = 2'd0;
	localparam logic [OP_W-1:0] OP_RECV  = 2'd1;
	localparam logic [OP_W-1:0] OP_ROUND = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_AB,
		ST_MUL_TH,
		ST_MUL_PI,
		ST_ACC
	} state_t;

	typedef enum logic [1:0] {
		SEL_AB,
		SEL_TH,
		SEL_PI
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_en;
	} ctrl_t;

endpackage

[rtl/scra_mul.sv]
// ----------------------------------------------------------------------------
// scra_mul: shared registered multiplier
// Keeps the low word of a 32 by 32 product, registered when enabled.
// ----------------------------------------------------------------------------
module scra_mul
	import scra_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [WORD_W-1:0] op_a,
	input  logic [WORD_W-1:0] op_b,
	output logic [WORD_W-1:0] prod
);

	logic [WORD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= op_a * op_b;
		end
	end

	assign prod = prod_q;

endmodule

[rtl/scra_ctrl.sv]
// ----------------------------------------------------------------------------
// scra_ctrl: item sequencer
// Steps a record through three multiplies and the accumulate, or goes straight
// to the accumulate for a round or unused opcode.
// ----------------------------------------------------------------------------
module scra_ctrl
	import scra_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [OP_W-1:0] opcode,
	input  logic            out_valid,
	input  logic            out_ready,
	output logic            in_ready,
	output ctrl_t           ctl
);

	state_t state_q;
	state_t state_d;
	logic   out_free;

	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (opcode == OP_SEND || opcode == OP_RECV) begin
						state_d = ST_MUL_AB;
					end else begin
						state_d = ST_ACC;
					end
				end
			end
			ST_MUL_AB: state_d = ST_MUL_TH;
			ST_MUL_TH: state_d = ST_MUL_PI;
			ST_MUL_PI: state_d = ST_ACC;
			ST_ACC: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		ctl.load    = 1'b0;
		ctl.mul_en  = 1'b0;
		ctl.mul_sel = SEL_AB;
		ctl.acc_en  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ctl.load = in_valid;
			end
			ST_MUL_AB: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = SEL_AB;
			end
			ST_MUL_TH: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = SEL_TH;
			end
			ST_MUL_PI: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = SEL_PI;
			end
			ST_ACC: begin
				ctl.acc_en = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

[rtl/send_receive_checksum_accumulator.sv]
// ----------------------------------------------------------------------------
// send_receive_checksum_accumulator: message checksum accumulator
// Records sent and received messages into two running sums and exchanges
// them with a round checksum when a round closes.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready) takes one beat per item: an opcode
// and the message fields. The output channel (out_valid, out_ready) returns
// one beat per item with the round checksum and the send and receive totals
// as they stand after that item.
// A record runs three multiplies in turn on one registered 32 by 32
// multiplier and then the accumulate step; a round or an unused opcode
// needs only the accumulate step. A new item is taken only in idle, once
// the previous item has finished its accumulate.
// The result sits in an output register. While the receiver stalls, the
// next item is still accepted and computed, and then waits in its
// accumulate cycle until the output register frees.
// Reset clears the three accumulators and the output valid flag.
// ----------------------------------------------------------------------------
module send_receive_checksum_accumulator
	import scra_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   opcode,
	input  logic [WORD_W-1:0] target_word,
	input  logic [WORD_W-1:0] record_id,
	input  logic [TYPE_W-1:0] msg_type,
	input  logic [WORD_W-1:0] context_id,
	input  logic [WORD_W-1:0] seq_number,
	input  logic [WORD_W-1:0] from_word,
	input  logic [WORD_W-1:0] to_word,
	input  logic [WORD_W-1:0] origin_word,
	input  logic              static_call,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] round_checksum,
	output logic [WORD_W-1:0] send_total,
	output logic [WORD_W-1:0] receive_total
);

	ctrl_t             ctl;
	logic [OP_W-1:0]   opcode_q;
	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] b_q;
	logic [WORD_W-1:0] c_q;
	logic [WORD_W-1:0] target_q;
	logic [WORD_W-1:0] id1_q;
	logic              static_q;
	logic [WORD_W-1:0] send_acc_q;
	logic [WORD_W-1:0] receive_acc_q;
	logic [WORD_W-1:0] round_acc_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] round_out_q;
	logic [WORD_W-1:0] send_out_q;
	logic [WORD_W-1:0] receive_out_q;
	logic [WORD_W-1:0] prod;
	logic [WORD_W-1:0] hash;
	logic [WORD_W-1:0] mul_a;
	logic [WORD_W-1:0] mul_b;
	logic [WORD_W-1:0] send_d;
	logic [WORD_W-1:0] receive_d;
	logic [WORD_W-1:0] round_d;

	scra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.opcode    (opcode),
		.out_valid (out_valid_q),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.ctl       (ctl)
	);

	// The three hash terms are formed while the beat is captured.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			opcode_q <= opcode;
			a_q      <= ~from_word + {{(WORD_W-TYPE_W){1'b0}}, msg_type};
			b_q      <= ~to_word + context_id;
			c_q      <= ~origin_word + seq_number;
			target_q <= target_word;
			id1_q    <= record_id + {{(WORD_W-1){1'b0}}, 1'b1};
			static_q <= static_call;
		end
	end

	assign hash = prod ^ c_q ^ {WORD_W{~static_q}};

	always_comb begin
		case (ctl.mul_sel)
			SEL_AB: begin
				mul_a = a_q;
				mul_b = b_q;
			end
			SEL_TH: begin
				mul_a = target_q;
				mul_b = hash;
			end
			SEL_PI: begin
				mul_a = prod;
				mul_b = id1_q;
			end
			default: begin
				mul_a = a_q;
				mul_b = b_q;
			end
		endcase
	end

	scra_mul u_mul (
		.clk  (clk),
		.en   (ctl.mul_en),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	always_comb begin
		send_d    = send_acc_q;
		receive_d = receive_acc_q;
		round_d   = round_acc_q;
		unique case (opcode_q)
			OP_SEND: send_d = send_acc_q + prod;
			OP_RECV: receive_d = receive_acc_q + prod;
			OP_ROUND: begin
				round_d   = send_acc_q;
				send_d    = send_acc_q ^ receive_acc_q;
				receive_d = receive_acc_q ^ round_acc_q;
			end
			OP_NONE: round_d = round_acc_q;
			default: round_d = round_acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_acc_q    <= '0;
			receive_acc_q <= '0;
			round_acc_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (ctl.acc_en) begin
				send_acc_q    <= send_d;
				receive_acc_q <= receive_d;
				round_acc_q   <= round_d;
				out_valid_q   <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.acc_en) begin
			round_out_q   <= round_d;
			send_out_q    <= send_d;
			receive_out_q <= receive_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign round_checksum = round_out_q;
	assign send_total     = send_out_q;
	assign receive_total  = receive_out_q;

	a_record_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (opcode == OP_SEND || opcode == OP_RECV) |=> ctl.mul_en)
		else $error("A record beat did not start the multiply sequence.");

	a_round_exchange: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.acc_en && opcode_q == OP_ROUND |=> round_acc_q == $past(send_acc_q)
			&& send_acc_q == ($past(send_acc_q) ^ $past(receive_acc_q)))
		else $error("Round exchange produced wrong accumulators.");

	a_unused_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.acc_en && opcode_q == OP_NONE |=> $stable(send_acc_q)
			&& $stable(receive_acc_q) && $stable(round_acc_q))
		else $error("An unused opcode changed the accumulators.");

	a_acc_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.acc_en |=> out_valid_q && send_out_q == send_acc_q)
		else $error("An accumulate did not present its result.");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.mul_en |-> !in_ready)
		else $error("Input accepted during the multiply sequence.");

endmodule

[tb/tb_send_receive_checksum_accumulator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_send_receive_checksum_accumulator: self-checking testbench
// A driver feeds send, receive, round and unused-opcode beats from a queue in
// random bursts while the receiver stalls on a rotating pattern. Every input
// beat is run through a local model of the three accumulators, and each
// output beat is checked field by field against the oldest predicted totals.
// ----------------------------------------------------------------------------
module tb_send_receive_checksum_accumulator
	import scra_pkg::*;
();

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [WORD_W-1:0] target;
		logic [WORD_W-1:0] rec_id;
		logic [TYPE_W-1:0] mtype;
		logic [WORD_W-1:0] ctx;
		logic [WORD_W-1:0] seq_w;
		logic [WORD_W-1:0] from_w;
		logic [WORD_W-1:0] to_w;
		logic [WORD_W-1:0] origin;
		logic              is_static;
		logic              drain_first;
	} msg_beat_t;

	typedef struct packed {
		logic [WORD_W-1:0] round_sum;
		logic [WORD_W-1:0] send_sum;
		logic [WORD_W-1:0] recv_sum;
	} totals_t;

	localparam int RANDOM_ITEMS = 1250;
	localparam int IDLE_LIMIT   = 1000;
	localparam int TAIL_CYCLES  = 20;
	localparam int REPORT_MAX   = 10;

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              in_valid       = 1'b0;
	logic              in_ready;
	logic [OP_W-1:0]   opcode         = OP_NONE;
	logic [WORD_W-1:0] target_word    = '0;
	logic [WORD_W-1:0] record_id      = '0;
	logic [TYPE_W-1:0] msg_type       = '0;
	logic [WORD_W-1:0] context_id     = '0;
	logic [WORD_W-1:0] seq_number     = '0;
	logic [WORD_W-1:0] from_word      = '0;
	logic [WORD_W-1:0] to_word        = '0;
	logic [WORD_W-1:0] origin_word    = '0;
	logic              static_call    = 1'b0;
	logic              out_valid;
	logic              out_ready      = 1'b0;
	logic [WORD_W-1:0] round_checksum;
	logic [WORD_W-1:0] send_total;
	logic [WORD_W-1:0] receive_total;

	msg_beat_t         beat_queue[$];
	totals_t           totals_queue[$];
	logic [WORD_W-1:0] acc_round      = '0;
	logic [WORD_W-1:0] acc_send       = '0;
	logic [WORD_W-1:0] acc_recv       = '0;
	logic              totals_pending = 1'b0;
	int                mismatches     = 0;
	int                burst_left     = 0;
	int                gap_left       = 0;
	logic [15:0]       ready_pattern  = 16'hffff;
	int                pattern_age    = 0;
	int                idle_cycles    = 0;

	send_receive_checksum_accumulator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.target_word    (target_word),
		.record_id      (record_id),
		.msg_type       (msg_type),
		.context_id     (context_id),
		.seq_number     (seq_number),
		.from_word      (from_word),
		.to_word        (to_word),
		.origin_word    (origin_word),
		.static_call    (static_call),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.round_checksum (round_checksum),
		.send_total     (send_total),
		.receive_total  (receive_total)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic msg_beat_t make_record(logic [OP_W-1:0] op, logic [WORD_W-1:0] id);
		msg_beat_t b;
		b.op          = op;
		b.target      = pick_word();
		b.rec_id      = id;
		b.mtype       = TYPE_W'($urandom_range(0, 255));
		b.ctx         = pick_word();
		b.seq_w       = pick_word();
		b.from_w      = pick_word();
		b.to_w        = pick_word();
		b.origin      = pick_word();
		b.is_static   = 1'($urandom_range(0, 1));
		b.drain_first = 1'b0;
		return b;
	endfunction

	function automatic msg_beat_t uniform_record(logic [OP_W-1:0] op, logic [WORD_W-1:0] w,
			logic st);
		msg_beat_t b;
		b.op          = op;
		b.target      = w;
		b.rec_id      = w;
		b.mtype       = w[TYPE_W-1:0];
		b.ctx         = w;
		b.seq_w       = w;
		b.from_w      = w;
		b.to_w        = w;
		b.origin      = w;
		b.is_static   = st;
		b.drain_first = 1'b0;
		return b;
	endfunction

	// Contribution of one message: target times hash times (id + 1), all mod 2^32.
	function automatic logic [WORD_W-1:0] record_term(msg_beat_t b);
		logic [WORD_W-1:0] term_a;
		logic [WORD_W-1:0] term_b;
		logic [WORD_W-1:0] term_c;
		logic [WORD_W-1:0] hash;
		term_a = ~b.from_w + WORD_W'(b.mtype);
		term_b = ~b.to_w + b.ctx;
		term_c = ~b.origin + b.seq_w;
		hash   = (term_a * term_b) ^ term_c;
		if (!b.is_static)
			hash = ~hash;
		return b.target * hash * (b.rec_id + 32'd1);
	endfunction

	task automatic predict_totals(input msg_beat_t b);
		logic [WORD_W-1:0] old_send;
		logic [WORD_W-1:0] old_recv;
		totals_t           t;
		old_send = acc_send;
		old_recv = acc_recv;
		case (b.op)
			OP_SEND: acc_send = acc_send + record_term(b);
			OP_RECV: acc_recv = acc_recv + record_term(b);
			OP_ROUND: begin
				acc_send  = old_send ^ old_recv;
				acc_recv  = old_recv ^ acc_round;
				acc_round = old_send;
			end
			default: ;
		endcase
		t.round_sum = acc_round;
		t.send_sum  = acc_send;
		t.recv_sum  = acc_recv;
		totals_queue.push_back(t);
	endtask

	task automatic queue_batch(input logic [OP_W-1:0] op, input int count);
		for (int i = 0; i < count; i++)
			beat_queue.push_back(make_record(op, i));
	endtask

	initial begin : stimulus
		msg_beat_t b;
		int        target_count;
		int        pick;
		beat_queue.push_back(uniform_record(OP_SEND, '0, 1'b0));
		beat_queue.push_back(uniform_record(OP_SEND, '1, 1'b1));
		beat_queue.push_back(uniform_record(OP_RECV, '1, 1'b0));
		beat_queue.push_back(make_record(OP_RECV, '1));
		beat_queue.push_back(make_record(OP_SEND, '1));
		beat_queue.push_back(make_record(OP_ROUND, pick_word()));
		beat_queue.push_back(make_record(OP_NONE, pick_word()));
		queue_batch(OP_SEND, 4);
		queue_batch(OP_RECV, 3);
		b = make_record(OP_ROUND, pick_word());
		b.drain_first = 1'b1;
		beat_queue.push_back(b);
		beat_queue.push_back(make_record(OP_ROUND, pick_word()));
		beat_queue.push_back(make_record(OP_NONE, pick_word()));
		b = make_record(OP_SEND, pick_word());
		b.mtype     = '0;
		b.is_static = 1'b1;
		beat_queue.push_back(b);
		b = make_record(OP_RECV, pick_word());
		b.mtype     = '1;
		b.is_static = 1'b0;
		beat_queue.push_back(b);
		beat_queue.push_back(make_record(OP_ROUND, pick_word()));

		// Mostly batches and single records, with rounds and unused opcodes mixed in at random.
		target_count = beat_queue.size() + RANDOM_ITEMS;
		while (beat_queue.size() < target_count) begin
			pick = $urandom_range(0, 19);
			if (pick < 3) begin
				b = make_record(OP_ROUND, pick_word());
			end else if (pick == 3) begin
				b = make_record(OP_NONE, pick_word());
			end else if (pick < 12) begin
				queue_batch(OP_W'($urandom_range(0, 1)), $urandom_range(1, 8));
				continue;
			end else if (pick < 18) begin
				b = make_record(OP_W'($urandom_range(0, 1)), pick_word());
			end else begin
				b = make_record(OP_W'($urandom_range(0, 3)), $urandom);
			end
			b.drain_first = ($urandom_range(0, 199) == 0);
			beat_queue.push_back(b);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (beat_queue.size() != 0 || in_valid || totals_pending)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		mismatches += totals_queue.size();
		if (mismatches == 0)
			$display("send_receive_checksum_accumulator test passed");
		else
			$display("send_receive_checksum_accumulator test failed");
		$finish;
	end

	always @(posedge clk) begin : driver
		if (arst_n) begin
			if (in_valid && in_ready) begin
				void'(beat_queue.pop_front());
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
			if (in_valid && !in_ready) begin
				in_valid <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (beat_queue.size() == 0 ||
					(beat_queue[0].drain_first && (in_valid || totals_pending))) begin
				in_valid <= 1'b0;
			end else begin
				in_valid    <= 1'b1;
				opcode      <= beat_queue[0].op;
				target_word <= beat_queue[0].target;
				record_id   <= beat_queue[0].rec_id;
				msg_type    <= beat_queue[0].mtype;
				context_id  <= beat_queue[0].ctx;
				seq_number  <= beat_queue[0].seq_w;
				from_word   <= beat_queue[0].from_w;
				to_word     <= beat_queue[0].to_w;
				origin_word <= beat_queue[0].origin;
				static_call <= beat_queue[0].is_static;
			end
		end
	end

	always @(posedge clk) begin : receiver
		if (pattern_age == 0) begin
			case ($urandom_range(0, 3))
				0: ready_pattern <= '1;
				1: ready_pattern <= 16'($urandom) | 16'h0001;
				2: ready_pattern <= 16'($urandom | $urandom) | 16'h0001;
				default: ready_pattern <= 16'($urandom & $urandom) | 16'h0001;
			endcase
			pattern_age <= 160;
		end else begin
			ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
			pattern_age   <= pattern_age - 1;
		end
		out_ready <= ready_pattern[0];
	end

	always @(posedge clk) begin : monitor
		totals_t   got;
		totals_t   want;
		msg_beat_t seen;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.round_sum = round_checksum;
				got.send_sum  = send_total;
				got.recv_sum  = receive_total;
				if (totals_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("Unexpected result beat: round %h send %h receive %h",
							got.round_sum, got.send_sum, got.recv_sum);
				end else begin
					want = totals_queue.pop_front();
					if (got.round_sum !== want.round_sum || got.send_sum !== want.send_sum ||
							got.recv_sum !== want.recv_sum) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("Mismatch: expected round %h send %h receive %h, ",
								want.round_sum, want.send_sum, want.recv_sum,
								"got round %h send %h receive %h",
								got.round_sum, got.send_sum, got.recv_sum);
					end
				end
			end
			if (in_valid && in_ready) begin
				seen.op          = opcode;
				seen.target      = target_word;
				seen.rec_id      = record_id;
				seen.mtype       = msg_type;
				seen.ctx         = context_id;
				seen.seq_w       = seq_number;
				seen.from_w      = from_word;
				seen.to_w        = to_word;
				seen.origin      = origin_word;
				seen.is_static   = static_call;
				seen.drain_first = 1'b0;
				predict_totals(seen);
			end
			totals_pending <= (totals_queue.size() != 0);
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("send_receive_checksum_accumulator test failed");
			$finish;
		end
	end

endmodule

[send_receive_checksum_accumulator.f]
rtl/scra_pkg.sv
rtl/scra_mul.sv
rtl/scra_ctrl.sv
rtl/send_receive_checksum_accumulator.sv
tb/tb_send_receive_checksum_accumulator.sv
